[design/lrb_pkg.sv]
// shared types and constants for the line-delimited receive ring buffer
`default_nettype none

package lrb_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int CHAR_W        = 8;
    localparam int COUNT_W       = 6;
    localparam int FUNC_W        = 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [COUNT_W-1:0] EMIT_MAX  = 6'd62;
    localparam logic [CHAR_W-1:0]  DELIM_RESET = 8'h0a;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RECV    = 3'd0,
        FUNC_READ    = 3'd1,
        FUNC_DISCARD = 3'd2,
        FUNC_LEN     = 3'd3,
        FUNC_CLEAR   = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_EMIT_RD,
        ST_EMIT_CHK,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic load;
        logic write_byte;
        logic clear_wr;
        logic cnt_inc;
        logic cnt_clr;
        logic take_string;
        logic skip_zero;
        logic set_comp;
        logic ptr_adv;
        logic emit_inc;
        logic push;
        logic push_char;
        logic push_last;
    } lrb_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ptr_at_wr;
        logic              ptr_at_term;
        logic              data_zero;
        logic              cnt_zero;
        logic              emit_done;
        logic              slot_free;
    } lrb_status_t;

endpackage

`default_nettype wire

[design/lrb_ctrl.sv]
// controller state machine sequencing receive, read, discard, length and clear
`default_nettype none

module lrb_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_accept,
    input  wire lrb_pkg::lrb_status_t status,
    output lrb_pkg::lrb_cmd_t         cmd,
    output logic                      idle
);
    import lrb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        idle       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (in_accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.func)
                    FUNC_RECV:
                    begin
                        cmd.write_byte = 1'b1;
                        state_next     = ST_FINAL;
                    end
                    FUNC_READ, FUNC_DISCARD, FUNC_LEN:
                    begin
                        state_next = ST_WALK_RD;
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.clear_wr = 1'b1;
                        state_next   = ST_FINAL;
                    end
                    default:
                    begin
                        state_next = ST_FINAL;
                    end
                endcase
            end
            ST_WALK_RD:
            begin
                if (status.ptr_at_wr)
                begin
                    // no terminator: read and discard report a zero count
                    if (status.func != FUNC_LEN)
                    begin
                        cmd.cnt_clr = 1'b1;
                    end
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK:
            begin
                if (status.func == FUNC_LEN)
                begin
                    if (status.data_zero && status.cnt_zero)
                    begin
                        cmd.skip_zero = 1'b1;
                        state_next    = ST_WALK_RD;
                    end
                    else if (status.data_zero)
                    begin
                        cmd.set_comp = 1'b1;
                        state_next   = ST_FINAL;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        cmd.ptr_adv = 1'b1;
                        state_next  = ST_WALK_RD;
                    end
                end
                else if (status.data_zero)
                begin
                    cmd.take_string = 1'b1;
                    state_next = (status.func == FUNC_READ) ? ST_EMIT_RD : ST_FINAL;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    cmd.ptr_adv = 1'b1;
                    state_next  = ST_WALK_RD;
                end
            end
            ST_EMIT_RD:
            begin
                if (status.ptr_at_term || status.emit_done)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_EMIT_CHK;
                end
            end
            ST_EMIT_CHK:
            begin
                if (status.slot_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_char = 1'b1;
                    cmd.ptr_adv   = 1'b1;
                    cmd.emit_inc  = 1'b1;
                    state_next    = ST_EMIT_RD;
                end
            end
            ST_FINAL:
            begin
                if (status.slot_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/lrb_dp.sv]
// datapath: byte store, indices, walk pointer, counters and output register
`default_nettype none

module lrb_dp #(
    parameter int DEPTH = lrb_pkg::DEPTH_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire lrb_pkg::lrb_cmd_t       cmd,
    output lrb_pkg::lrb_status_t         status,
    input  wire  [lrb_pkg::FUNC_W-1:0]   in_func,
    input  wire  [lrb_pkg::CHAR_W-1:0]   in_byte,
    input  wire                          cfg_we,
    input  wire  [lrb_pkg::CHAR_W-1:0]   cfg_wdata,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [lrb_pkg::CHAR_W-1:0]   out_char,
    output logic [lrb_pkg::COUNT_W-1:0]  out_count,
    output logic                         out_complete,
    output logic                         out_last,
    output logic                         out_full
);
    import lrb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

    logic [CHAR_W-1:0]  mem [DEPTH];
    logic [CHAR_W-1:0]  rdata_reg;
    logic [AW-1:0]      wr_idx_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      term_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] emit_reg;
    logic               comp_reg;
    logic [FUNC_W-1:0]  func_reg;
    logic [CHAR_W-1:0]  byte_reg;
    logic [CHAR_W-1:0]  delim_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_complete_reg;
    logic               out_last_reg;
    logic               out_full_reg;

    logic [AW-1:0]      rd_before;
    logic               full;
    logic [AW-1:0]      wr_nxt;
    logic [AW-1:0]      ptr_nxt;
    logic               slot_free;

    assign rd_before = (rd_idx_reg == '0) ? IDX_LAST : rd_idx_reg - AW'(1);
    assign full      = (wr_idx_reg == rd_before);
    assign wr_nxt    = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + AW'(1);
    assign ptr_nxt   = (ptr_reg == IDX_LAST) ? '0 : ptr_reg + AW'(1);
    assign slot_free = !out_valid_reg || out_ready;

    assign status.func        = func_reg;
    assign status.ptr_at_wr   = (ptr_reg == wr_idx_reg);
    assign status.ptr_at_term = (ptr_reg == term_reg);
    assign status.data_zero   = (rdata_reg == '0);
    assign status.cnt_zero    = (cnt_reg == '0);
    assign status.emit_done   = (emit_reg == EMIT_MAX);
    assign status.slot_free   = slot_free;

    // byte store, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.write_byte && !full)
        begin
            mem[wr_idx_reg] <= (byte_reg == delim_reg) ? '0 : byte_reg;
        end
        rdata_reg <= mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            delim_reg  <= DELIM_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                delim_reg <= cfg_wdata;
            end
            if (cmd.write_byte && !full)
            begin
                wr_idx_reg <= wr_nxt;
            end
            if (cmd.clear_wr)
            begin
                wr_idx_reg <= rd_idx_reg;
            end
            if (cmd.take_string || cmd.skip_zero)
            begin
                rd_idx_reg <= ptr_nxt;
            end
        end
    end

    // walk state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            byte_reg <= in_byte;
            ptr_reg  <= rd_idx_reg;
            cnt_reg  <= '0;
            emit_reg <= '0;
            comp_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            if (cmd.cnt_inc && cnt_reg != COUNT_MAX)
            begin
                cnt_reg <= cnt_reg + COUNT_W'(1);
            end
            if (cmd.take_string)
            begin
                term_reg <= ptr_reg;
                ptr_reg  <= rd_idx_reg;
                comp_reg <= 1'b1;
            end
            if (cmd.set_comp)
            begin
                comp_reg <= 1'b1;
            end
            if (cmd.ptr_adv || cmd.skip_zero)
            begin
                ptr_reg <= ptr_nxt;
            end
            if (cmd.emit_inc)
            begin
                emit_reg <= emit_reg + COUNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_char_reg     <= cmd.push_char ? rdata_reg : '0;
            out_count_reg    <= cnt_reg;
            out_complete_reg <= comp_reg;
            out_last_reg     <= cmd.push_last;
            out_full_reg     <= full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign out_count    = out_count_reg;
    assign out_complete = out_complete_reg;
    assign out_last     = out_last_reg;
    assign out_full     = out_full_reg;

    a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> slot_free)
        else $error("word pushed over an untaken result");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_byte && !full) |=> (wr_idx_reg != rd_idx_reg))
        else $error("write index ran onto read index");

    a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_inc |-> (emit_reg < EMIT_MAX))
        else $error("too many characters emitted");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_idx_reg <= IDX_LAST) && (rd_idx_reg <= IDX_LAST))
        else $error("index beyond store depth");

endmodule

`default_nettype wire

[design/line_delimited_rx_ring_buffer.sv]
// top level of the line-delimited receive ring buffer
//
// channel   dir  tdata                         tuser                 tlast
// s_axis    in   [7:0] rx_byte                 [2:0] func            -
// m_axis    out  [7:0] char_out, [13:8] count  [0] complete, [1] full last
// cfg       in   cfg_wdata = delimiter, written when cfg_we is high
//
// receive, clear, spare codes: dispatch, then the final state pushes the result word
// read, discard, length: each stored byte walked takes a read state and a check state
//   (store read is registered); read then emits each character through a read state and
//   a check state, and the final state pushes the closing word
// one word in flight at a time; a stalled output holds the walk in place
// reset clears indices and control; the byte store needs no clearing
`default_nettype none

module line_delimited_rx_ring_buffer #(
    parameter int DEPTH = lrb_pkg::DEPTH_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire  [2:0]  s_axis_tuser,   // [2:0] func
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [13:8] count, [15:14] zero
    output logic [1:0]  m_axis_tuser,   // [0] complete, [1] full_res
    output logic        m_axis_tlast,
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata
);
    import lrb_pkg::*;

    lrb_cmd_t           cmd;
    lrb_status_t        status;
    logic               idle;
    logic               in_accept;
    logic [CHAR_W-1:0]  out_char;
    logic [COUNT_W-1:0] out_count;
    logic               out_complete;
    logic               out_full;

    assign s_axis_tready = idle;
    assign in_accept     = s_axis_tvalid && idle;

    lrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .status    (status),
        .cmd       (cmd),
        .idle      (idle)
    );

    lrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_func      (s_axis_tuser),
        .in_byte      (s_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_char     (out_char),
        .out_count    (out_count),
        .out_complete (out_complete),
        .out_last     (m_axis_tlast),
        .out_full     (out_full)
    );

    assign m_axis_tdata = {2'b00, out_count, out_char};
    assign m_axis_tuser = {out_full, out_complete};

endmodule

`default_nettype wire
